// ===== rtl/core/b64e_pkg.sv =====
// shared types, constants and the character mapping of the base64 encoder
`default_nettype none

package b64e_pkg;

  // characters one input byte can produce at most
  localparam int unsigned NCHAR = 4;
  localparam int unsigned CIDX_W = $clog2(NCHAR);

  // depth of the queue between front and back
  localparam int unsigned QDEPTH = 2;

  // pad character '='
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // position in the three-byte group
  typedef enum logic [1:0] {
    PH_G0 = 2'd0,
    PH_G1 = 2'd1,
    PH_G2 = 2'd2
  } b64e_phase_t;

  // one work item handed from front to back
  typedef struct packed {
    logic [NCHAR-1:0][7:0] chars;
    logic [CIDX_W-1:0]     last_idx;
    logic                  fin;
  } b64e_entry_t;

  // standard alphabet lookup for a 6-bit value
  function automatic logic [7:0] sextet(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] ch;
    w = {2'b00, v};
    if (v < 6'd26) begin
      ch = 8'(w + 8'h41);
    end else if (v < 6'd52) begin
      ch = 8'(w + 8'd71);
    end else if (v < 6'd62) begin
      ch = 8'(w - 8'd4);
    end else if (v == 6'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/base64_stream_encoder_core.sv =====
// Streaming base64 encoder, standard alphabet with '=' padding.
// Input channel: one raw byte per beat (in_data_byte) with in_final_byte marking
// the last byte of a message; every message ends with a final byte.
// Output channel: one ASCII character per beat (out_char); out_run_end marks the
// last character caused by an input byte, out_message_end the last character
// of the whole encoded message.
// An ordinary byte yields one or two characters, a final byte two to four
// (the zero-filled tail character and the '=' pads the group position needs).
// A character passes through the queue storage and then the output register.
// Throughput: the output side moves one character per cycle while out_ready
// is high; the input side takes one byte per cycle while the two-entry queue
// between the byte front end and the character back end has room. The back
// end's single output register sets the character rate.
// When the receiver stalls, the output register holds its character and the
// queue fills; in_ready drops only once the queue is full.
// Reset clears the group position, leftover bits, queue and output valid;
// the block then starts at the beginning of a three-byte group.
`default_nettype none

module base64_stream_encoder_core
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_final_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_run_end,
  output logic            out_message_end
);

  logic        push_valid, push_ready;
  b64e_entry_t push_entry;
  logic        pop_valid, pop;
  b64e_entry_t pop_entry;

  // byte front end
  b64e_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  // entry queue
  b64e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  // character back end
  b64e_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop             (pop),
    .pop_entry       (pop_entry),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_run_end     (out_run_end),
    .out_message_end (out_message_end)
  );

endmodule

`default_nettype wire

// ===== rtl/core/b64e_front.sv =====
// front end: accepts bytes, tracks group position and builds character entries
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_final_byte,
  output logic             push_valid,
  input  wire logic        push_ready,
  output b64e_entry_t      push_entry
);

  b64e_phase_t phase_r, phase_nxt;
  logic [3:0]  left_r, left_nxt;
  logic        accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // next group position and leftover bits
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    if (accept) begin
      unique case (phase_r)
        PH_G1: begin
          phase_nxt = PH_G2;
          left_nxt  = in_data_byte[3:0];
        end
        PH_G2: begin
          phase_nxt = PH_G0;
          left_nxt  = 4'd0;
        end
        default: begin
          phase_nxt = PH_G1;
          left_nxt  = {2'b00, in_data_byte[1:0]};
        end
      endcase
      if (in_final_byte) begin
        phase_nxt = PH_G0;
        left_nxt  = 4'd0;
      end
    end
  end

  // characters this byte completes, plus flush and pad on the final byte
  always_comb begin
    push_entry.chars    = {NCHAR{PAD_CHAR}};
    push_entry.fin      = in_final_byte;
    push_entry.last_idx = CIDX_W'(0);
    unique case (phase_r)
      PH_G1: begin
        push_entry.chars[0] = sextet({left_r[1:0], in_data_byte[7:4]});
        push_entry.chars[1] = sextet({in_data_byte[3:0], 2'b00});
        push_entry.last_idx = in_final_byte ? CIDX_W'(2) : CIDX_W'(0);
      end
      PH_G2: begin
        push_entry.chars[0] = sextet({left_r, in_data_byte[7:6]});
        push_entry.chars[1] = sextet(in_data_byte[5:0]);
        push_entry.last_idx = CIDX_W'(1);
      end
      default: begin
        push_entry.chars[0] = sextet(in_data_byte[7:2]);
        push_entry.chars[1] = sextet({in_data_byte[1:0], 4'b0000});
        push_entry.last_idx = in_final_byte ? CIDX_W'(3) : CIDX_W'(0);
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_G0;
      left_r  <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b64e_queue.sv =====
// short fifo of character entries between front and back
`default_nettype none

module b64e_queue
  import b64e_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push_valid,
  output logic        push_ready,
  input  b64e_entry_t push_entry,
  output logic        pop_valid,
  input  wire logic   pop,
  output b64e_entry_t pop_entry
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  b64e_entry_t       mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != CNT_W'(0));
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? PTR_W'(0) : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? PTR_W'(0) : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= PTR_W'(0);
      rd_ptr_r <= PTR_W'(0);
      cnt_r    <= CNT_W'(0);
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b64e_back.sv =====
// back end: walks the head entry one character per beat into the output register
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        pop_valid,
  output logic             pop,
  input  b64e_entry_t      pop_entry,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_char,
  output logic             out_run_end,
  output logic             out_message_end
);

  logic [CIDX_W-1:0] idx_r, idx_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [7:0]        char_r;
  logic              run_end_r, msg_end_r;
  logic              load, is_last;

  assign load    = pop_valid && (!ovalid_r || out_ready);
  assign is_last = (idx_r == pop_entry.last_idx);
  assign pop     = load && is_last;

  // character index within the head entry and output valid
  always_comb begin
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
    if (load) begin
      ovalid_nxt = 1'b1;
      idx_nxt    = is_last ? CIDX_W'(0) : CIDX_W'(idx_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= CIDX_W'(0);
      ovalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      char_r    <= pop_entry.chars[idx_r];
      run_end_r <= is_last;
      msg_end_r <= is_last && pop_entry.fin;
    end
  end

  assign out_valid       = ovalid_r;
  assign out_char        = char_r;
  assign out_run_end     = run_end_r;
  assign out_message_end = msg_end_r;

endmodule

`default_nettype wire

// ===== rtl/core/b64e_checker.sv =====
// port-level checks for the base64 encoder, bound to the top level
`default_nettype none

module b64e_checker
  import b64e_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       out_run_end,
  input wire logic       out_message_end
);

  // nothing shows on the output right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a stalled beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char)
      && $stable(out_run_end) && $stable(out_message_end))
    else $error("stalled output beat changed");

  // the message end is always the last character of its byte
  a_msg_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_end |-> out_run_end)
    else $error("message end without run end");

  // a pad closing a byte's run closes the message
  a_pad_ends_msg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_end && out_char == PAD_CHAR |-> out_message_end)
    else $error("trailing pad not marked as message end");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (.*);

`default_nettype wire
